FILE: rtl/spc_pkg.sv
// Package with the constants and the fixed-point helper of the skin pixel classifier.
`default_nettype none
package spc_pkg;

   // Line coefficients and offsets in units of 1/10000.
   localparam longint LINE_A_K_NUM = 64'sd15862;
   localparam longint LINE_A_C_NUM = 64'sd200000;
   localparam longint LINE_B_K_NUM = 64'sd3448;
   localparam longint LINE_B_C_NUM = 64'sd762069;
   localparam longint LINE_C_K_NUM = -64'sd45652;
   localparam longint LINE_C_C_NUM = 64'sd2345652;
   localparam longint LINE_D_K_NUM = -64'sd11500;
   localparam longint LINE_D_C_NUM = 64'sd3017500;
   localparam longint LINE_E_K_NUM = -64'sd22857;
   localparam longint LINE_E_C_NUM = 64'sd4328500;

   // Headroom above the fraction bits for every line value and scaled Cr.
   localparam int LINE_INT_BITS = 12;

   localparam logic [7:0] DAY_RED_MIN    = 8'd95;
   localparam logic [7:0] DAY_GREEN_MIN  = 8'd40;
   localparam logic [7:0] DAY_BLUE_MIN   = 8'd20;
   localparam logic [7:0] FLASH_RED_MIN  = 8'd220;
   localparam logic [7:0] FLASH_GREEN_MIN = 8'd210;
   localparam logic [7:0] FLASH_BLUE_MIN = 8'd170;
   localparam logic [7:0] SPREAD_MIN     = 8'd15;
   localparam logic [7:0] HUE_LOW        = 8'd25;
   localparam logic [7:0] HUE_HIGH       = 8'd230;

   typedef struct packed {
      logic rgb_skin;
      logic chroma_skin;
      logic hue_skin;
   } flags_type;

   // Scales a value given in 1/10000 units to frac_bits fraction bits,
   // rounding half away from zero.
   function automatic longint fx_const(input longint num, input int frac_bits);
      longint mag;
      longint scaled;
      mag = (num < 0) ? -num : num;
      scaled = (mag * (longint'(1) << frac_bits) + 64'sd5000) / 64'sd10000;
      return (num < 0) ? -scaled : scaled;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/spc_chroma_check.sv
// Five fixed-point line tests of Cr against Cb for the chroma skin flag.
`default_nettype none
module spc_chroma_check #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic [7:0] chroma_red,
   input  wire logic [7:0] chroma_blue,
   output logic            chroma_skin
);
   import spc_pkg::*;

   localparam int W = FRACTION_BITS + LINE_INT_BITS;

   localparam logic signed [W-1:0] K_A = W'(fx_const(LINE_A_K_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] C_A = W'(fx_const(LINE_A_C_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] K_B = W'(fx_const(LINE_B_K_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] C_B = W'(fx_const(LINE_B_C_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] K_C = W'(fx_const(LINE_C_K_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] C_C = W'(fx_const(LINE_C_C_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] K_D = W'(fx_const(LINE_D_K_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] C_D = W'(fx_const(LINE_D_C_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] K_E = W'(fx_const(LINE_E_K_NUM, FRACTION_BITS));
   localparam logic signed [W-1:0] C_E = W'(fx_const(LINE_E_C_NUM, FRACTION_BITS));

   logic signed [W-1:0] cr_scaled;
   logic signed [W-1:0] cb_ext;
   logic signed [W-1:0] line_a;
   logic signed [W-1:0] line_b;
   logic signed [W-1:0] line_c;
   logic signed [W-1:0] line_d;
   logic signed [W-1:0] line_e;

   assign cr_scaled = signed'(W'({chroma_red, {FRACTION_BITS{1'b0}}}));
   assign cb_ext    = signed'(W'(chroma_blue));

   assign line_a = K_A * cb_ext + C_A;
   assign line_b = K_B * cb_ext + C_B;
   assign line_c = K_C * cb_ext + C_C;
   assign line_d = K_D * cb_ext + C_D;
   assign line_e = K_E * cb_ext + C_E;

   assign chroma_skin = (cr_scaled <= line_a) && (cr_scaled >= line_b) &&
                        (cr_scaled >= line_c) && (cr_scaled <= line_d) &&
                        (cr_scaled <= line_e);

endmodule
`default_nettype wire

FILE: rtl/skin_pixel_classifier.sv
// Top level of the skin pixel classifier: input register, flag logic and result register.
`default_nettype none
// One pixel word is taken at every clock edge where start is high; busy is always
// low, so a new word may follow in every cycle. The word is loaded into the input
// register, its flags are computed from it and loaded into the result register, and
// from there the three flags appear on the rsp_ ports, marked by rsp_valid. The
// receiver cannot stall, so each result is marked by rsp_valid for a single cycle only.
// The throughput is one pixel per clock, set by the single pass of flag logic between
// the two registers; there is no state carried between pixels.
module skin_pixel_classifier #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_chroma_red,
   input  wire logic [7:0] req_chroma_blue,
   input  wire logic [7:0] req_hue,
   output logic            rsp_valid,
   output logic            rsp_rgb_skin,
   output logic            rsp_chroma_skin,
   output logic            rsp_hue_skin
);
   import spc_pkg::*;

   logic       in_valid_ff;
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;
   logic [7:0] cr_ff;
   logic [7:0] cb_ff;
   logic [7:0] hue_ff;

   logic       out_valid_ff;
   flags_type  flags_ff;
   flags_type  flags_in;

   logic [7:0] max_val;
   logic [7:0] min_val;
   logic [7:0] rg_diff;
   logic       day_ok;
   logic       flash_ok;
   logic       chroma_ok;
   logic       hue_ok;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         cr_ff    <= req_chroma_red;
         cb_ff    <= req_chroma_blue;
         hue_ff   <= req_hue;
      end
      if (in_valid_ff) begin
         flags_ff <= flags_in;
      end
   end

   always_comb begin
      max_val = red_ff;
      min_val = red_ff;
      if (green_ff > max_val) max_val = green_ff;
      if (blue_ff > max_val) max_val = blue_ff;
      if (green_ff < min_val) min_val = green_ff;
      if (blue_ff < min_val) min_val = blue_ff;
      rg_diff = (red_ff >= green_ff) ? (red_ff - green_ff) : (green_ff - red_ff);
   end

   assign day_ok = (red_ff > DAY_RED_MIN) && (green_ff > DAY_GREEN_MIN) &&
                   (blue_ff > DAY_BLUE_MIN) && ((max_val - min_val) > SPREAD_MIN) &&
                   (rg_diff > SPREAD_MIN) && (red_ff > green_ff) && (red_ff > blue_ff);

   assign flash_ok = (red_ff > FLASH_RED_MIN) && (green_ff > FLASH_GREEN_MIN) &&
                     (blue_ff > FLASH_BLUE_MIN) && (rg_diff <= SPREAD_MIN) &&
                     (red_ff > blue_ff) && (green_ff > blue_ff);

   assign hue_ok = (hue_ff < HUE_LOW) || (hue_ff > HUE_HIGH);

   // Field order of the word: rgb_skin, chroma_skin, hue_skin.
   assign flags_in = {day_ok || flash_ok, chroma_ok, hue_ok};

   spc_chroma_check #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_chroma (
      .chroma_red  (cr_ff),
      .chroma_blue (cb_ff),
      .chroma_skin (chroma_ok)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_rgb_skin    = flags_ff.rgb_skin;
   assign rsp_chroma_skin = flags_ff.chroma_skin;
   assign rsp_hue_skin    = flags_ff.hue_skin;

endmodule
`default_nettype wire

FILE: rtl/spc_checker.sv
// Port-level checks of the skin pixel classifier and their binding to the top level.
`default_nettype none
module spc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [7:0] req_red,
   input wire logic [7:0] req_blue,
   input wire logic [7:0] req_hue,
   input wire logic       rsp_valid,
   input wire logic       rsp_rgb_skin,
   input wire logic       rsp_hue_skin
);
   import spc_pkg::*;

   // The block never refuses a word.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy was raised");

   // Every accepted word gives a result through the input and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted word produced no result");

   // No result appears without an accepted word that passed the input and result registers.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted word");

   // The hue flag matches the hue of the word it belongs to.
   a_hue_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue_skin ==
         (($past(req_hue, 2) < HUE_LOW) || ($past(req_hue, 2) > HUE_HIGH))))
      else $error("hue flag does not match its word");

   // Both RGB rules need red above blue.
   a_rgb_red_over_blue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rgb_skin) |-> ($past(req_red, 2) > $past(req_blue, 2)))
      else $error("RGB flag set with red not above blue");

endmodule

bind skin_pixel_classifier spc_checker u_spc_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_red      (req_red),
   .req_blue     (req_blue),
   .req_hue      (req_hue),
   .rsp_valid    (rsp_valid),
   .rsp_rgb_skin (rsp_rgb_skin),
   .rsp_hue_skin (rsp_hue_skin)
);
`default_nettype wire
